// ===== hw/rtl/ldcs_pkg.sv =====
package ldcs_pkg;

    // command codes
    localparam logic [2:0] OP_SOFT_RESET = 3'd0;
    localparam logic [2:0] OP_PRE_ACTIVE = 3'd1;
    localparam logic [2:0] OP_WRITE_CONF = 3'd2;
    localparam logic [2:0] OP_ENABLE_ALL = 3'd3;
    localparam logic [2:0] OP_DISABLE_ALL = 3'd4;
    localparam logic [2:0] OP_SEND_DATA = 3'd5;
    localparam logic [2:0] OP_VSYNC = 3'd6;
    localparam logic [2:0] OP_UNDEFINED = 3'd7;

    // pulse counter and pattern limits
    localparam int unsigned CNT_W = 6;
    localparam logic [CNT_W-1:0] WORD_LAST_PULSE = 6'd15;
    localparam logic [CNT_W-1:0] VSYNC_LAST_PULSE = 6'd56;
    localparam logic [CNT_W-1:0] VSYNC_LATCH_FIRST = 6'd54;
    localparam logic [CNT_W-1:0] WRCONF_LATCH_FIRST = 6'd12;
    localparam logic [CNT_W-1:0] SEND_LATCH_FIRST = 6'd15;
    localparam logic [CNT_W-1:0] SOFT_RESET_LATCH_END = 6'd10;
    localparam logic [CNT_W-1:0] PRE_ACTIVE_LATCH_END = 6'd14;
    localparam logic [CNT_W-1:0] ENABLE_ALL_LATCH_END = 6'd11;
    localparam logic [CNT_W-1:0] DISABLE_ALL_LATCH_END = 6'd12;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] data_word;
        logic        latch_request;
    } t_in_item;

    typedef struct packed {
        logic sdi_level;
        logic latch_level;
        logic last_pulse;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_legal;
        logic pulse_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/led_driver_command_serializer.sv =====
// led driver command serializer
// input channel: one item holds an opcode, a 16-bit data word and a latch
// request; i_in_valid / o_in_ready with the item taken when both are high.
// output channel: one item per serial clock pulse with the data level, the
// latch level at the rising edge and a mark on the final pulse.
// each command gives 16 pulses, vsync gives 57; opcode 7 is taken and dropped.
// after an item is taken the controller runs and its first pulse is issued
// when the output register is free; the pulse counter issues at most one
// pulse a cycle into a single output register. a new item is taken in the
// cycle the last pulse of the previous one is issued, with no gap between.
// an output stall holds the pulse counter and the output register; nothing
// is dropped, and input is refused until the last pulse is issued.
// reset empties the output register, returns the controller to idle and
// clears the held data level used by data-less commands.
module led_driver_command_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ldcs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ldcs_pkg::t_out_item o_out_item
);

    ldcs_pkg::t_dp_cmd    cmd;
    ldcs_pkg::t_dp_status status;

    // sequencing
    ldcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // pulse generation
    ldcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hw/rtl/ldcs_ctrl.sv =====
module ldcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ldcs_pkg::t_dp_status i_status,
    output ldcs_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   finishing;

    // pulse issue and item acceptance
    always_comb begin
        o_cmd.step = (r_state == S_RUN) && i_status.out_free;
        finishing  = o_cmd.step && i_status.pulse_last;
        o_in_ready = (r_state == S_IDLE) || finishing;
        accept     = i_in_valid && o_in_ready;
        o_cmd.load = accept && i_status.op_legal;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_RUN;
            end
            S_RUN: begin
                if (finishing) n_state = o_cmd.load ? S_RUN : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    a_load_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_in_valid)
        else $error("load without an input item");
    a_step_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (r_state == S_RUN))
        else $error("pulse issued while idle");
    a_idle_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finishing && !o_cmd.load) |=> (r_state == S_IDLE))
        else $error("controller kept running after last pulse");

endmodule

// ===== hw/rtl/ldcs_dp.sv =====
module ldcs_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ldcs_pkg::t_in_item   i_in_item,
    input  ldcs_pkg::t_dp_cmd    i_cmd,
    output ldcs_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ldcs_pkg::t_out_item  o_out_item
);

    logic [2:0]                    r_op;
    logic [15:0]                   r_shift;
    logic                          r_req;
    logic [ldcs_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_held;
    logic                          r_out_valid;
    ldcs_pkg::t_out_item           r_out;
    ldcs_pkg::t_out_item           pulse;
    logic                          word_op;
    logic                          in_word_op;

    // decode of the incoming item
    always_comb begin
        in_word_op = (i_in_item.opcode == ldcs_pkg::OP_WRITE_CONF)
                  || (i_in_item.opcode == ldcs_pkg::OP_SEND_DATA);
    end

    // current pulse pattern
    always_comb begin
        word_op = (r_op == ldcs_pkg::OP_WRITE_CONF) || (r_op == ldcs_pkg::OP_SEND_DATA);
        pulse.sdi_level = word_op ? r_shift[15] : r_held;
        pulse.last_pulse = (r_op == ldcs_pkg::OP_VSYNC)
                         ? (r_cnt == ldcs_pkg::VSYNC_LAST_PULSE)
                         : (r_cnt == ldcs_pkg::WORD_LAST_PULSE);
        unique case (r_op)
            ldcs_pkg::OP_SOFT_RESET:
                pulse.latch_level = (r_cnt != '0) && (r_cnt <= ldcs_pkg::SOFT_RESET_LATCH_END);
            ldcs_pkg::OP_PRE_ACTIVE:
                pulse.latch_level = (r_cnt != '0) && (r_cnt <= ldcs_pkg::PRE_ACTIVE_LATCH_END);
            ldcs_pkg::OP_ENABLE_ALL:
                pulse.latch_level = (r_cnt != '0) && (r_cnt <= ldcs_pkg::ENABLE_ALL_LATCH_END);
            ldcs_pkg::OP_DISABLE_ALL:
                pulse.latch_level = (r_cnt != '0)
                                 && (r_cnt <= ldcs_pkg::DISABLE_ALL_LATCH_END);
            ldcs_pkg::OP_WRITE_CONF:
                pulse.latch_level = r_req && (r_cnt >= ldcs_pkg::WRCONF_LATCH_FIRST);
            ldcs_pkg::OP_SEND_DATA:
                pulse.latch_level = r_req && (r_cnt >= ldcs_pkg::SEND_LATCH_FIRST);
            ldcs_pkg::OP_VSYNC:
                pulse.latch_level = (r_cnt >= ldcs_pkg::VSYNC_LATCH_FIRST);
            default:
                pulse.latch_level = 1'b0;
        endcase
        o_status.op_legal   = (i_in_item.opcode != ldcs_pkg::OP_UNDEFINED);
        o_status.pulse_last = pulse.last_pulse;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // command registers, shift register and pulse counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_item.opcode;
            r_shift <= i_in_item.data_word;
            r_req   <= i_in_item.latch_request;
            r_cnt   <= '0;
        end else if (i_cmd.step) begin
            r_shift <= {r_shift[14:0], 1'b0};
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    // data level kept for data-less commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (i_cmd.load && in_word_op) begin
            r_held <= i_in_item.data_word[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out <= pulse;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks
    a_step_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || i_out_ready))
        else $error("pulse would overwrite an untaken item");
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_cnt <= ldcs_pkg::VSYNC_LAST_PULSE))
        else $error("pulse counter past the longest command");
    a_out_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> o_out_valid)
        else $error("issued pulse not presented");

endmodule

// ===== tb/sv/ldcs_pulse_monitor.sv =====
module ldcs_pulse_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ldcs_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ldcs_pkg::t_out_item i_out_item,
    output int                  o_err_cnt,
    output int                  o_pend_cnt,
    output int                  o_pulse_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    // pulses still owed by the block, oldest first
    ldcs_pkg::t_out_item pending_pulses[$];
    // data level repeated by data-less commands
    logic                held_sdi = 1'b0;
    ldcs_pkg::t_out_item want;
    int                  err_cnt = 0;
    int                  pulse_cnt = 0;

    assign o_err_cnt   = err_cnt;
    assign o_pulse_cnt = pulse_cnt;

    initial o_pend_cnt = 0;

    // turn one command into the pulses it should produce
    function automatic void expand_command(ldcs_pkg::t_in_item cmd);
        logic [ldcs_pkg::CNT_W-1:0] latch_end;
        logic [ldcs_pkg::CNT_W-1:0] latch_first;
        ldcs_pkg::t_out_item        p;
        int                         k;
        latch_end   = '0;
        latch_first = '0;
        case (cmd.opcode)
            ldcs_pkg::OP_SOFT_RESET:  latch_end = ldcs_pkg::SOFT_RESET_LATCH_END;
            ldcs_pkg::OP_PRE_ACTIVE:  latch_end = ldcs_pkg::PRE_ACTIVE_LATCH_END;
            ldcs_pkg::OP_ENABLE_ALL:  latch_end = ldcs_pkg::ENABLE_ALL_LATCH_END;
            ldcs_pkg::OP_DISABLE_ALL: latch_end = ldcs_pkg::DISABLE_ALL_LATCH_END;
            ldcs_pkg::OP_WRITE_CONF:  latch_first = ldcs_pkg::WRCONF_LATCH_FIRST;
            ldcs_pkg::OP_SEND_DATA:   latch_first = ldcs_pkg::SEND_LATCH_FIRST;
            default:                  ;
        endcase
        case (cmd.opcode) inside
            // latch window from pulse 1, data line holds its last level
            ldcs_pkg::OP_SOFT_RESET, ldcs_pkg::OP_PRE_ACTIVE, ldcs_pkg::OP_ENABLE_ALL,
            ldcs_pkg::OP_DISABLE_ALL: begin
                for (k = 0; k <= ldcs_pkg::WORD_LAST_PULSE; k++) begin
                    p.sdi_level   = held_sdi;
                    p.latch_level = (k >= 1) && (k <= latch_end);
                    p.last_pulse  = (k == ldcs_pkg::WORD_LAST_PULSE);
                    pending_pulses.push_back(p);
                end
            end
            // word shifted msb first, latch only on request
            ldcs_pkg::OP_WRITE_CONF, ldcs_pkg::OP_SEND_DATA: begin
                for (k = 0; k <= ldcs_pkg::WORD_LAST_PULSE; k++) begin
                    p.sdi_level   = cmd.data_word[15 - k];
                    p.latch_level = cmd.latch_request && (k >= latch_first);
                    p.last_pulse  = (k == ldcs_pkg::WORD_LAST_PULSE);
                    pending_pulses.push_back(p);
                end
                held_sdi = cmd.data_word[0];
            end
            // long frame with latch at the tail
            ldcs_pkg::OP_VSYNC: begin
                for (k = 0; k <= ldcs_pkg::VSYNC_LAST_PULSE; k++) begin
                    p.sdi_level   = held_sdi;
                    p.latch_level = (k >= ldcs_pkg::VSYNC_LATCH_FIRST);
                    p.last_pulse  = (k == ldcs_pkg::VSYNC_LAST_PULSE);
                    pending_pulses.push_back(p);
                end
            end
            // undefined opcode is dropped without output
            default: ;
        endcase
    endfunction

    // compare delivered pulses, then queue pulses of accepted commands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_pulses.delete();
            held_sdi = 1'b0;
            o_pend_cnt <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                pulse_cnt++;
                if (pending_pulses.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected pulse sdi=%b le=%b last=%b", $realtime,
                                 i_out_item.sdi_level, i_out_item.latch_level,
                                 i_out_item.last_pulse);
                end else begin
                    want = pending_pulses.pop_front();
                    if (i_out_item.sdi_level !== want.sdi_level ||
                        i_out_item.latch_level !== want.latch_level ||
                        i_out_item.last_pulse !== want.last_pulse) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%0t: pulse mismatch exp sdi=%b le=%b last=%b,",
                                      " got sdi=%b le=%b last=%b"},
                                     $realtime, want.sdi_level, want.latch_level,
                                     want.last_pulse, i_out_item.sdi_level,
                                     i_out_item.latch_level, i_out_item.last_pulse);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expand_command(i_in_item);
            o_pend_cnt <= pending_pulses.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 90;
    localparam int TAIL_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    ldcs_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    ldcs_pkg::t_out_item out_item;

    int err_cnt;
    int pend_cnt;
    int pulse_cnt;
    int snd_idle = 33;
    int rcv_idle = 71;
    int quiet_cycles = 0;
    int cmd_cnt = 0;
    int vsync_cnt = 0;
    int drop_cnt = 0;

    always #4 clk = ~clk;

    led_driver_command_serializer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    ldcs_pulse_monitor mon (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_item (out_item),
        .o_err_cnt  (err_cnt),
        .o_pend_cnt (pend_cnt),
        .o_pulse_cnt(pulse_cnt)
    );

    // random receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // stop the run if no item moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("** led_driver_command_serializer: FAILED **");
            $finish;
        end
    end

    function automatic ldcs_pkg::t_in_item make_cmd(logic [2:0] op, logic [15:0] word,
                                                   logic req);
        ldcs_pkg::t_in_item c;
        c.opcode        = op;
        c.data_word     = word;
        c.latch_request = req;
        return c;
    endfunction

    // weighted random command, word commands most often
    function automatic ldcs_pkg::t_in_item random_cmd();
        int          r;
        logic [2:0]  op;
        logic [15:0] word;
        r = $urandom_range(99);
        if (r < 5)
            op = ldcs_pkg::OP_UNDEFINED;
        else if (r < 15)
            op = ldcs_pkg::OP_VSYNC;
        else if (r < 40)
            op = ldcs_pkg::OP_WRITE_CONF;
        else if (r < 65)
            op = ldcs_pkg::OP_SEND_DATA;
        else begin
            case ($urandom_range(3))
                0:       op = ldcs_pkg::OP_SOFT_RESET;
                1:       op = ldcs_pkg::OP_PRE_ACTIVE;
                2:       op = ldcs_pkg::OP_ENABLE_ALL;
                default: op = ldcs_pkg::OP_DISABLE_ALL;
            endcase
        end
        case ($urandom_range(9))
            0:       word = 16'h0000;
            1:       word = 16'hffff;
            default: word = 16'($urandom_range(65535));
        endcase
        return make_cmd(op, word, 1'($urandom_range(1)));
    endfunction

    // offer one item after random idle cycles and wait for its acceptance
    task automatic send_cmd(ldcs_pkg::t_in_item cmd);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= cmd;
        do @(posedge clk); while (!in_ready);
        if (cmd.opcode == ldcs_pkg::OP_UNDEFINED)
            drop_cnt++;
        else
            cmd_cnt++;
        if (cmd.opcode == ldcs_pkg::OP_VSYNC)
            vsync_cnt++;
    endtask

    initial begin
        ldcs_pkg::t_in_item cmd;
        int                 sent;
        int                 phase;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every opcode, word extremes, held level both ways
        send_cmd(make_cmd(ldcs_pkg::OP_SOFT_RESET, 16'h0000, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_WRITE_CONF, 16'hffff, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_SOFT_RESET, 16'hffff, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_PRE_ACTIVE, 16'h0000, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_ENABLE_ALL, 16'hffff, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_DISABLE_ALL, 16'h0000, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_VSYNC, 16'hffff, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_SEND_DATA, 16'h0000, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_VSYNC, 16'h0000, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_PRE_ACTIVE, 16'hffff, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_ENABLE_ALL, 16'h0000, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_DISABLE_ALL, 16'hffff, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_WRITE_CONF, 16'h0000, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_WRITE_CONF, 16'h8001, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_WRITE_CONF, 16'h5555, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_SEND_DATA, 16'hffff, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_SEND_DATA, 16'haaaa, 1'b1));
        // undefined opcode must leave the held level alone
        send_cmd(make_cmd(ldcs_pkg::OP_UNDEFINED, 16'hffff, 1'b1));
        send_cmd(make_cmd(ldcs_pkg::OP_SOFT_RESET, 16'h0000, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_SEND_DATA, 16'h5555, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_UNDEFINED, 16'h0000, 1'b0));
        send_cmd(make_cmd(ldcs_pkg::OP_VSYNC, 16'h0000, 1'b0));

        // random commands under three stall profiles
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle = 33;
                    rcv_idle = 71;
                end
                1: begin
                    snd_idle = 71;
                    rcv_idle = 33;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                cmd = random_cmd();
                send_cmd(cmd);
                if (cmd.opcode != ldcs_pkg::OP_UNDEFINED)
                    sent++;
            end
        end
        in_valid <= 1'b0;

        // drain and let the block settle
        @(posedge clk);
        while (pend_cnt != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands (%0d vsync) and %0d undefined opcodes",
                 cmd_cnt, vsync_cnt, drop_cnt);
        $display("under three stall profiles: %0d pulses checked, %0d mismatches, %0d missing",
                 pulse_cnt, err_cnt, pend_cnt);
        if (err_cnt == 0 && pend_cnt == 0) begin
            $display("** led_driver_command_serializer: PASSED **");
        end else begin
            $display("** led_driver_command_serializer: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ldcs_pkg.sv
hw/rtl/ldcs_ctrl.sv
hw/rtl/ldcs_dp.sv
hw/rtl/led_driver_command_serializer.sv
tb/sv/ldcs_pulse_monitor.sv
tb/sv/tb.sv
